@@ rtl/frd_pkg.sv @@
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types and constants for the fixed ring deque: operation codes,
// transaction payload structs and default sizes.
// ----------------------------------------------------------------------------
package frd_pkg;

   // Default sizes for the top-level parameters
   localparam int DEPTH_DEFAULT      = 16;
   localparam int ITEM_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels
   localparam int OP_W    = 3;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int COUNT_W = 5;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

   // Request transaction payload
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] item_data;
   } req_type;

   // Response transaction payload
   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
      logic               is_full;
      logic [DATA_W-1:0]  front_value;
      logic [DATA_W-1:0]  rear_value;
   } rsp_type;

endpackage

@@ rtl/frd_ram.sv @@
// ----------------------------------------------------------------------------
// frd_ram
// Generic synchronous RAM: one write port, two read ports, registered read
// data with a read enable. No reset on the array.
// ----------------------------------------------------------------------------
module frd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and capture both read ports when enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

@@ rtl/frd_wrap.sv @@
// ----------------------------------------------------------------------------
// frd_wrap
// Iterative remainder unit: reduces a pointer value modulo the capacity in
// use, one dividend bit per cycle (restoring scheme).
// ----------------------------------------------------------------------------
module frd_wrap
   import frd_pkg::*;
#(
   parameter int DIV_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [CAP_W-1:0]   divisor,
   output logic               done,
   output logic [CAP_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [DIV_W-1:0]   shift_ff, shift_in;
   logic [CAP_W-1:0]   rem_ff,   rem_in;
   logic [CAP_W-1:0]   div_ff,   div_in;
   logic [CAP_W:0]     trial;
   logic [CAP_W-1:0]   step_rem;

   // One restoring step: bring in the next bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, shift_ff[DIV_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         step_rem = CAP_W'(trial - {1'b0, div_ff});
      end else begin
         step_rem = trial[CAP_W-1:0];
      end
   end

   // Load on start, advance while busy, flag the last step
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(DIV_W);
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = step_rem;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/fixed_ring_deque_core.sv @@
// ----------------------------------------------------------------------------
// fixed_ring_deque_core
// Double-ended queue of fixed-width entries held in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one operation per
//   transaction: push back, push front, pop front, pop rear or peek.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one transaction per
//   request: success, entry count, empty/full flags and both end entries.
//   csr_wr_en/csr_wr_data set the capacity in use; write only while idle.
// Timing:
//   A request is processed in steps: accept and RAM write, RAM read of
//   both end entries, response load into the output register. A new
//   request is taken only after the previous one has loaded its response.
//   A front push or rear pop whose pointer lies beyond a reduced capacity
//   runs the iterative remainder unit first, in an extra wrap step.
// Reset:
//   Pointers and count clear, capacity returns to 16 (limited to DEPTH).
//   The RAM is not cleared; end entries are reported only while the queue holds entries.
// Stall:
//   A waiting response sits in the output register while the next request
//   is accepted; that request then holds in its load step until the output
//   register is taken.
// ----------------------------------------------------------------------------
module fixed_ring_deque_core
   import frd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int IDX_W = PTR_W + 1;
   localparam int CMP_W = (IDX_W > CAP_W) ? IDX_W : CAP_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WRAP = 4'b0010,
      ST_READ = 4'b0100,
      ST_LOAD = 4'b1000
   } state_type;

   state_type             state_ff,     state_in;
   logic [PTR_W-1:0]      front_ff,     front_in;
   logic [PTR_W-1:0]      rear_ff,      rear_in;
   logic [COUNT_W-1:0]    count_ff,     count_in;
   logic [CAP_W-1:0]      capacity_ff,  capacity_in;
   logic                  wrap_front_ff, wrap_front_in;
   logic                  pend_push_ff, pend_push_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  acc_ff,       acc_in;
   logic [ITEM_WIDTH-1:0] pend_item_ff, pend_item_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   logic [CAP_W-1:0]      cap_eff;
   logic [CMP_W-1:0]      cap_x;
   logic [PTR_W-1:0]      cap_last;
   logic [CMP_W-1:0]      front_x, rear_x;
   logic [PTR_W-1:0]      front_up, rear_up, front_dn, rear_dn;
   logic                  front_wrap_need, rear_wrap_need;
   logic [ITEM_WIDTH-1:0] item_w;

   logic                  mem_we, mem_re;
   logic [PTR_W-1:0]      mem_waddr;
   logic [ITEM_WIDTH-1:0] mem_wdata;
   logic [ITEM_WIDTH-1:0] mem_rdata_front, mem_rdata_rear;

   logic                  wrap_start, wrap_done;
   logic [IDX_W-1:0]      wrap_dividend;
   logic [CAP_W-1:0]      wrap_rem;

   // Clamp the capacity register into 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   // Candidate pointer moves
   always_comb begin
      cap_x           = CMP_W'(cap_eff);
      cap_last        = PTR_W'(cap_eff - CAP_W'(1));
      front_x         = CMP_W'(front_ff) + CMP_W'(1);
      rear_x          = CMP_W'(rear_ff) + CMP_W'(1);
      front_up        = (front_x < cap_x) ? PTR_W'(front_x) : '0;
      rear_up         = (rear_x < cap_x) ? PTR_W'(rear_x) : '0;
      front_wrap_need = front_x > cap_x;
      rear_wrap_need  = rear_x > cap_x;
      front_dn        = (front_ff == '0) ? cap_last : front_ff - PTR_W'(1);
      rear_dn         = (rear_ff == '0) ? cap_last : rear_ff - PTR_W'(1);
      item_w          = ITEM_WIDTH'(req_data.item_data);
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer: decode, update pointers, write, read back, load response
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      count_in      = count_ff;
      wrap_front_in = wrap_front_ff;
      pend_push_in  = pend_push_ff;
      pend_item_in  = pend_item_ff;
      acc_in        = acc_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = item_w;
      mem_re        = 1'b0;
      wrap_start    = 1'b0;
      wrap_dividend = '0;

      // Drop the response once it is taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in       = 1'b0;
               pend_push_in = 1'b0;
               state_in     = ST_READ;
               case (req_data.op)
                  OP_PUSH_BACK, OP_PUSH_FRONT: begin
                     if (count_ff == '0) begin
                        front_in  = '0;
                        rear_in   = '0;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        count_in  = COUNT_W'(1);
                        acc_in    = 1'b1;
                     end else if (count_ff < cap_eff) begin
                        count_in = count_ff + COUNT_W'(1);
                        acc_in   = 1'b1;
                        if (req_data.op == OP_PUSH_BACK) begin
                           rear_in   = rear_dn;
                           mem_we    = 1'b1;
                           mem_waddr = rear_dn;
                        end else if (front_wrap_need) begin
                           wrap_start    = 1'b1;
                           wrap_dividend = IDX_W'(front_x);
                           wrap_front_in = 1'b1;
                           pend_push_in  = 1'b1;
                           pend_item_in  = item_w;
                           state_in      = ST_WRAP;
                        end else begin
                           front_in  = front_up;
                           mem_we    = 1'b1;
                           mem_waddr = front_up;
                        end
                     end
                  end
                  OP_POP_FRONT: begin
                     if (count_ff != '0) begin
                        front_in = front_dn;
                        count_in = count_ff - COUNT_W'(1);
                        acc_in   = 1'b1;
                     end
                  end
                  OP_POP_REAR: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                        acc_in   = 1'b1;
                        if (rear_wrap_need) begin
                           wrap_start    = 1'b1;
                           wrap_dividend = IDX_W'(rear_x);
                           wrap_front_in = 1'b0;
                           state_in      = ST_WRAP;
                        end else begin
                           rear_in = rear_up;
                        end
                     end
                  end
                  OP_PEEK: begin
                     acc_in = 1'b1;
                  end
                  default: begin
                     acc_in = 1'b0;
                  end
               endcase
            end
         end
         ST_WRAP: begin
            // Finish the deferred pointer move and any pending write
            if (wrap_done) begin
               if (wrap_front_ff) begin
                  front_in = PTR_W'(wrap_rem);
               end else begin
                  rear_in = PTR_W'(wrap_rem);
               end
               mem_we    = pend_push_ff;
               mem_waddr = PTR_W'(wrap_rem);
               mem_wdata = pend_item_ff;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.accepted    = acc_ff;
               rsp_data_in.entry_count = count_ff;
               rsp_data_in.is_empty    = (count_ff == '0);
               rsp_data_in.is_full     = (count_ff != '0) && (count_ff == cap_eff);
               rsp_data_in.front_value = (count_ff != '0) ? DATA_W'(mem_rdata_front) : '0;
               rsp_data_in.rear_value  = (count_ff != '0) ? DATA_W'(mem_rdata_rear) : '0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capacity register
   always_comb begin
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         front_ff      <= '0;
         rear_ff       <= '0;
         count_ff      <= '0;
         capacity_ff   <= CAP_RESET;
         wrap_front_ff <= 1'b0;
         pend_push_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         acc_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         count_ff      <= count_in;
         capacity_ff   <= capacity_in;
         wrap_front_ff <= wrap_front_in;
         pend_push_ff  <= pend_push_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_ff        <= acc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_item_ff <= pend_item_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   frd_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_en     (mem_re),
      .rd_addr_a (front_ff),
      .rd_addr_b (rear_ff),
      .rd_data_a (mem_rdata_front),
      .rd_data_b (mem_rdata_rear)
   );

   frd_wrap #(
      .DIV_W (IDX_W)
   ) u_wrap (
      .clock     (clock),
      .reset     (reset),
      .start     (wrap_start),
      .dividend  (wrap_dividend),
      .divisor   (cap_eff),
      .done      (wrap_done),
      .remainder (wrap_rem)
   );

endmodule

@@ rtl/frd_checker.sv @@
// ----------------------------------------------------------------------------
// frd_checker
// Port-level assertions for the fixed ring deque, bound to the top level.
// ----------------------------------------------------------------------------
module frd_checker
   import frd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Empty flag agrees with the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   // Empty queue reports zero end entries and is not full
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.front_value == '0 && rsp_data.rear_value == '0 && !rsp_data.is_full)
      else $error("empty response carries end entries or full flag");

   // One request in flight: no back-to-back acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

endmodule

bind fixed_ring_deque_core frd_checker u_checker (.*);
